// File: hw/rtl/iida_pkg.sv
// Package for the indexed insert/delete array: item types, command,
// status and datapath operation codes. No dependencies.
`timescale 1ns / 1ps

package iida_pkg;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  index;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [4:0]  count;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_RD_IDX,
    OP_CAPTURE,
    OP_RD_INS,
    OP_WR_SHIFT_INS,
    OP_WR_INS,
    OP_RD_DEL,
    OP_WR_SHIFT_DEL,
    OP_DEC,
    OP_RESULT
  } op_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       range_err;
    logic       full_err;
    logic       more_ins;
    logic       more_del;
    logic       out_busy;
  } stat_t;

endpackage

// File: hw/rtl/iida_datapath.sv
// Datapath: entry memory, fill count, command registers, shift pointer
// and result register. Uses iida_pkg; driven by iida_ctrl.
`timescale 1ns / 1ps

module iida_datapath import iida_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  op_t       op,
  output stat_t     stat,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 8) ? CW : 8;

  logic [ELEM_WIDTH-1:0] mem [CAPACITY];
  logic [ELEM_WIDTH-1:0] rd_data;
  logic [ELEM_WIDTH-1:0] held;
  logic [ELEM_WIDTH-1:0] val_r;
  logic [1:0]            cmd_r;
  logic [7:0]            idx_r;
  logic                  range_r;
  logic                  full_r;
  logic [CW-1:0]         fill;
  logic [AW-1:0]         ptr;

  logic [AW-1:0]         idx_a;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic                  wr_en;
  logic [ELEM_WIDTH-1:0] wr_data;
  logic [XW-1:0]         in_idx_x;
  logic [XW-1:0]         fill_x;
  logic                  in_range;
  logic                  in_full;
  logic [ELEM_WIDTH+31:0] in_val_ext;
  logic [ELEM_WIDTH+31:0] held_ext;
  logic [CW+4:0]         fill_ext;
  logic [1:0]            status_code;

  assign idx_a      = idx_r[AW-1:0];
  assign in_idx_x   = XW'(in_item.index);
  assign fill_x     = XW'(fill);
  assign in_val_ext = {{ELEM_WIDTH{1'b0}}, in_item.value};
  assign held_ext   = {32'd0, held};
  assign fill_ext   = {5'd0, fill};

  always_comb begin
    in_range = 1'b0;
    in_full  = 1'b0;
    case (in_item.cmd)
      CMD_READ, CMD_DELETE: in_range = (in_idx_x >= fill_x);
      CMD_INSERT: begin
        in_range = (in_idx_x > fill_x);
        in_full  = (fill == CW'(CAPACITY));
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.cmd       = cmd_r;
    stat.range_err = range_r;
    stat.full_err  = full_r;
    stat.more_ins  = (ptr > idx_a);
    stat.more_del  = ((CW'(ptr) + CW'(1)) < fill);
    stat.out_busy  = out_valid && out_stall;
  end

  always_comb begin
    rd_addr = idx_a;
    wr_addr = ptr;
    wr_en   = 1'b0;
    wr_data = rd_data;
    case (op)
      OP_RD_IDX:       rd_addr = idx_a;
      OP_RD_INS:       rd_addr = ptr - AW'(1);
      OP_RD_DEL:       rd_addr = ptr + AW'(1);
      OP_WR_SHIFT_INS: wr_en = 1'b1;
      OP_WR_SHIFT_DEL: wr_en = 1'b1;
      OP_WR_INS: begin
        wr_en   = 1'b1;
        wr_addr = idx_a;
        wr_data = val_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    if (range_r) begin
      status_code = ST_RANGE;
    end else if (full_r) begin
      status_code = ST_FULL;
    end else begin
      status_code = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        cmd_r   <= in_item.cmd;
        idx_r   <= in_item.index;
        val_r   <= in_val_ext[ELEM_WIDTH-1:0];
        range_r <= in_range;
        full_r  <= in_full;
        if (in_item.cmd == CMD_INSERT) begin
          ptr <= fill[AW-1:0];
        end else begin
          ptr <= in_item.index[AW-1:0];
        end
      end
      OP_CAPTURE:      held <= rd_data;
      OP_WR_SHIFT_INS: ptr <= ptr - AW'(1);
      OP_WR_SHIFT_DEL: ptr <= ptr + AW'(1);
      OP_RESULT: begin
        out_item.status <= status_code;
        out_item.count  <= fill_ext[4:0];
        if (!range_r && (cmd_r == CMD_READ || cmd_r == CMD_DELETE)) begin
          out_item.value_out <= held_ext[31:0];
        end else begin
          out_item.value_out <= 32'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (op)
        OP_WR_INS: fill <= fill + CW'(1);
        OP_DEC:    fill <= fill - CW'(1);
        default: ;
      endcase
      if (op == OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/iida_ctrl.sv
// Controller state machine: sequences the read, insert and delete steps
// of the datapath. Uses iida_pkg.
`timescale 1ns / 1ps

module iida_ctrl import iida_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output op_t   op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CAPT,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_CHK,
    S_DEL_WR,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op         = OP_IDLE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.range_err || stat.full_err) begin
          state_next = S_RESULT;
        end else begin
          case (stat.cmd)
            CMD_READ, CMD_DELETE: begin
              op         = OP_RD_IDX;
              state_next = S_CAPT;
            end
            CMD_INSERT: state_next = S_INS_CHK;
            default:    state_next = S_RESULT;
          endcase
        end
      end
      S_CAPT: begin
        op = OP_CAPTURE;
        if (stat.cmd == CMD_READ) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_DEL_CHK;
        end
      end
      S_INS_CHK: begin
        if (stat.more_ins) begin
          op         = OP_RD_INS;
          state_next = S_INS_WR;
        end else begin
          op         = OP_WR_INS;
          state_next = S_RESULT;
        end
      end
      S_INS_WR: begin
        op         = OP_WR_SHIFT_INS;
        state_next = S_INS_CHK;
      end
      S_DEL_CHK: begin
        if (stat.more_del) begin
          op         = OP_RD_DEL;
          state_next = S_DEL_WR;
        end else begin
          op         = OP_DEC;
          state_next = S_RESULT;
        end
      end
      S_DEL_WR: begin
        op         = OP_WR_SHIFT_DEL;
        state_next = S_DEL_CHK;
      end
      S_RESULT: begin
        if (!stat.out_busy) begin
          op         = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/indexed_insert_delete_array.sv
// Top level of the indexed insert/delete array: controller plus datapath.
// Uses iida_pkg, iida_ctrl and iida_datapath.
//
// Usage:
//   Input channel in_valid/in_stall/in_item carries one command per item:
//   read, insert or delete at an index. Output channel out_valid/out_stall/
//   out_item returns exactly one result per command: status, value and the
//   entry count after the command.
//   One item is worked on at a time; in_stall is low only while idle.
//   Steps per command: a range error, full error or unused command goes
//   straight to the result; a read reads and captures the entry; an insert
//   shifts the entries at and above the index up by one, then writes the
//   value; a delete captures the entry, shifts the entries above it down
//   and decrements the count. The controller moves one entry at a time:
//   each shifted entry takes a read step and a write step. The next item
//   can be taken in the cycle after the result is registered.
//   A stalled result is held in the output register; the block finishes
//   the next item up to its result and then waits for that register.
//   Reset empties the array (count zero) and clears the output valid flag.
`timescale 1ns / 1ps

module indexed_insert_delete_array import iida_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  op_t   op;
  stat_t stat;

  iida_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  iida_datapath #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .stat      (stat),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted while busy");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status == ST_FULL) |-> (out_item.count == 5'(CAPACITY)))
    else $error("full status with count below capacity");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status != ST_OK) |-> (out_item.value_out == 32'd0))
    else $error("nonzero value on error result");
`endif

endmodule

// File: verif/indexed_insert_delete_array_tb.sv
// Self-checking testbench for indexed_insert_delete_array: a shadow array
// predicts each read/insert/delete result. Random idling on both channels.
// Depends on iida_pkg and the indexed_insert_delete_array RTL.
`timescale 1ns / 1ps

module indexed_insert_delete_array_tb;
  import iida_pkg::*;

  localparam int CAPACITY          = 16;
  localparam int ELEM_WIDTH        = 32;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STUCK_LIMIT       = 2000;
  localparam int DRAIN_CYCLES      = 60;
  localparam int MAX_PRINTED       = 100;

  class array_scoreboard;
    logic [ELEM_WIDTH-1:0] cells[CAPACITY];
    int unsigned fill;
    int unsigned peak_fill;
    out_item_t   pending[$];
    int          errors;
    int          cmd_seen[4];
    int          status_seen[4];

    function new();
      fill      = 0;
      peak_fill = 0;
      errors    = 0;
      foreach (cmd_seen[k]) cmd_seen[k] = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function void note_command(input in_item_t it);
      out_item_t r;
      int unsigned i;
      r.status    = ST_OK;
      r.value_out = '0;
      case (it.cmd)
        CMD_READ: begin
          if (it.index >= fill) r.status = ST_RANGE;
          else r.value_out = cells[it.index];
        end
        CMD_INSERT: begin
          if (it.index > fill) r.status = ST_RANGE;
          else if (fill >= CAPACITY) r.status = ST_FULL;
          else begin
            for (i = fill; i > it.index; i--) cells[i] = cells[i-1];
            cells[it.index] = it.value[ELEM_WIDTH-1:0];
            fill++;
          end
        end
        CMD_DELETE: begin
          if (it.index >= fill) r.status = ST_RANGE;
          else begin
            r.value_out = cells[it.index];
            for (i = it.index; i + 1 < fill; i++) cells[i] = cells[i+1];
            fill--;
          end
        end
        default: ;
      endcase
      r.count = fill[4:0];
      if (fill > peak_fill) peak_fill = fill;
      cmd_seen[it.cmd]++;
      status_seen[r.status]++;
      pending.push_back(r);
    endfunction

    task check_result(input out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report("result with no command outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.value_out !== want.value_out)
        report($sformatf("value_out %h, expected %h", got.value_out, want.value_out));
      if (got.count !== want.count)
        report($sformatf("count %0d, expected %0d", got.count, want.count));
    endtask
  endclass

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  array_scoreboard sb;
  bit sender_idle_on = 1'b1;
  bit sink_idle_on   = 1'b1;
  int stall_left     = 0;
  int stuck          = 0;
  int results_seen   = 0;

  indexed_insert_delete_array #(
    .CAPACITY  (CAPACITY),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Called at a falling edge; returns at a falling edge after the item is taken.
  task automatic send(input logic [1:0] c, input logic [7:0] idx, input logic [31:0] v);
    in_item_t it;
    int gap;
    it.cmd   = c;
    it.index = idx;
    it.value = v;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_command(it);
    @(negedge clk);
    if (sender_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed commands for the current fill level, plus some noise.
  task automatic random_item(input int insert_weight);
    int roll;
    int n;
    logic [1:0] c;
    logic [7:0] idx;
    n    = sb.fill;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      c   = 2'($urandom_range(0, 3));
      idx = 8'($urandom_range(0, 255));
    end else if (roll < 13) begin
      c   = 2'($urandom_range(0, 2));
      idx = 8'(n + $urandom_range(0, 2));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < insert_weight || n == 0) begin
        c   = CMD_INSERT;
        idx = 8'($urandom_range(0, n));
      end else begin
        c   = (roll < insert_weight + (100 - insert_weight) / 2) ? CMD_DELETE : CMD_READ;
        idx = 8'($urandom_range(0, n - 1));
      end
    end
    send(c, idx, $urandom());
  endtask

  always @(negedge clk) begin
    if (sink_idle_on && stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (sink_idle_on && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(out_item);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                 STUCK_LIMIT, sb.pending.size());
        $display("indexed_insert_delete_array test failed");
        $finish;
      end
    end
  end

  initial begin
    int k;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty array, boundaries
    send(CMD_READ, 8'd0, 32'h0);
    send(CMD_DELETE, 8'd0, 32'hFFFF_FFFF);
    send(CMD_INSERT, 8'd1, 32'h1234_5678);
    send(CMD_INSERT, 8'd0, 32'hFFFF_FFFF);
    send(CMD_INSERT, 8'd1, 32'h0000_0000);
    send(CMD_INSERT, 8'd0, 32'hA5A5_A5A5);
    send(CMD_INSERT, 8'd1, 32'h5A5A_5A5A);
    for (k = 4; k < CAPACITY; k++)
      send(CMD_INSERT, (k % 2 == 0) ? 8'(sb.fill / 2) : 8'(sb.fill), $urandom());
    // full array
    send(CMD_INSERT, 8'd0, 32'hDEAD_BEEF);
    send(CMD_INSERT, 8'(CAPACITY), 32'hDEAD_BEEF);
    send(CMD_INSERT, 8'(CAPACITY + 1), 32'hDEAD_BEEF);
    send(CMD_READ, 8'd0, 32'h0);
    send(CMD_READ, 8'(CAPACITY - 1), 32'h0);
    send(CMD_READ, 8'(CAPACITY), 32'h0);
    send(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    send(CMD_DELETE, 8'hFF, 32'h0);
    send(CMD_DELETE, 8'(CAPACITY - 1), 32'h0);
    send(CMD_DELETE, 8'd0, 32'h0);
    send(CMD_DELETE, 8'd7, 32'h0);
    hold_until_drained();

    repeat (150) random_item(60);
    repeat (150) random_item(25);
    repeat (150) random_item(45);
    hold_until_drained();
    repeat (150) random_item(60);

    sender_idle_on = 1'b0;
    sink_idle_on   = 1'b0;
    repeat (150) random_item(45);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("commands: %0d read, %0d insert, %0d delete, %0d unused; peak fill %0d of %0d",
             sb.cmd_seen[CMD_READ], sb.cmd_seen[CMD_INSERT], sb.cmd_seen[CMD_DELETE],
             sb.cmd_seen[CMD_UNUSED], sb.peak_fill, CAPACITY);
    $display("%0d results checked: %0d ok, %0d out of range, %0d full; %0d mismatches",
             results_seen, sb.status_seen[ST_OK], sb.status_seen[ST_RANGE],
             sb.status_seen[ST_FULL], sb.errors);
    if (sb.errors == 0) begin
      $display("indexed_insert_delete_array test passed");
    end else begin
      $display("indexed_insert_delete_array test failed");
    end
    $finish;
  end

endmodule
